@@ hdl/imd_pkg.sv @@
// Shared constants and handshake types for the integer matrix determinant block.
package imd_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int DATA_W      = 32;
  localparam int SIZE_W      = 4;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd2;
  localparam int CFG_AW      = 2;
  localparam logic [CFG_AW-1:0] REG_MATRIX_SIZE = 2'd0;

  typedef struct packed {
    logic start;      // all elements of a matrix are stored
    logic res_ready;  // output register can take a word
  } eng_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] det;
  } eng_rsp_t;

endpackage

@@ hdl/imd_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module imd_ram #(
  parameter int W = 32,
  parameter int D = 64
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                       wdata,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                       rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/imd_engine.sv @@
// Subset-minor engine: expands every column-subset minor along its bottom row.
module imd_engine #(
  parameter int MAX_DIM = imd_pkg::MAX_DIM_DEF
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  imd_pkg::eng_req_t                                     req,
  input  logic [$clog2(MAX_DIM+1)-1:0]                          dim,
  output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1)-1:0] mat_raddr,
  input  logic [imd_pkg::DATA_W-1:0]                            mat_rdata,
  output imd_pkg::eng_rsp_t                                     rsp
);
  import imd_pkg::*;

  localparam int DW = $clog2(MAX_DIM+1);
  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_START = 3'd1;
  localparam logic [2:0] ST_RD    = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_ACC   = 3'd4;
  localparam logic [2:0] ST_WR    = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [MAX_DIM-1:0] mask_r, mask_nxt;
  logic [MAX_DIM-1:0] full_r, full_nxt;
  logic [CW-1:0]      col_r, col_nxt;
  logic [CW-1:0]      row_r, row_nxt;
  logic               par_r, par_nxt;
  logic               sub_zero_r, sub_zero_nxt;
  logic [DATA_W-1:0]  acc_r, acc_nxt;
  logic [DATA_W-1:0]  prod_r, prod_nxt;

  logic [MAX_DIM-1:0] col_bit;
  logic [MAX_DIM-1:0] sub_mask;
  logic [DW-1:0]      dim_m1;
  logic               last_col;
  logic [DW-1:0]      pop;
  logic [DATA_W-1:0]  min_rdata;
  logic               min_we;

  assign col_bit  = MAX_DIM'(1) << col_r;
  assign sub_mask = mask_r & ~col_bit;
  assign dim_m1   = dim - DW'(1);
  assign last_col = (DW'(col_r) == dim_m1);
  assign min_we   = (state_r == ST_WR);

  always_comb begin
    pop = '0;
    for (int i = 0; i < MAX_DIM; i++) begin
      pop = pop + DW'(mask_r[i]);
    end
  end

  assign mat_raddr = AW'(int'(row_r) * MAX_DIM + int'(col_r));

  imd_ram #(.W(DATA_W), .D(1 << MAX_DIM)) u_minor_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (mask_r),
    .wdata (acc_r),
    .raddr (sub_mask),
    .rdata (min_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    mask_nxt     = mask_r;
    full_nxt     = full_r;
    col_nxt      = col_r;
    row_nxt      = row_r;
    par_nxt      = par_r;
    sub_zero_nxt = sub_zero_r;
    acc_nxt      = acc_r;
    prod_nxt     = prod_r;
    rsp.done     = 1'b0;
    rsp.det      = acc_r;
    unique case (state_r)
      ST_IDLE: begin
        if (req.start) begin
          mask_nxt  = MAX_DIM'(1);
          full_nxt  = MAX_DIM'(((MAX_DIM+1)'(1) << dim) - (MAX_DIM+1)'(1));
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        row_nxt   = CW'(pop - DW'(1));
        par_nxt   = row_nxt[0];
        col_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_RD;
      end
      ST_RD: begin
        sub_zero_nxt = (sub_mask == '0);
        if (mask_r[col_r]) begin
          state_nxt = ST_MUL;
        end else if (last_col) begin
          state_nxt = ST_WR;
        end else begin
          col_nxt = col_r + CW'(1);
        end
      end
      ST_MUL: begin
        // the empty minor is one
        prod_nxt  = mat_rdata * (sub_zero_r ? DATA_W'(1) : min_rdata);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = par_r ? (acc_r - prod_r) : (acc_r + prod_r);
        par_nxt = ~par_r;
        if (last_col) begin
          state_nxt = ST_WR;
        end else begin
          col_nxt   = col_r + CW'(1);
          state_nxt = ST_RD;
        end
      end
      ST_WR: begin
        if (mask_r == full_r) begin
          state_nxt = ST_DONE;
        end else begin
          mask_nxt  = mask_r + MAX_DIM'(1);
          state_nxt = ST_START;
        end
      end
      ST_DONE: begin
        if (req.res_ready) begin
          rsp.done  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mask_r     <= mask_nxt;
    full_r     <= full_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    par_r      <= par_nxt;
    sub_zero_r <= sub_zero_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
  end

endmodule

@@ hdl/integer_matrix_determinant.sv @@
// Integer matrix determinant: configuration, element loading and result register.
//
// Usage: set matrix_size (1..8, 0 reads as 1, larger saturates) through the
// APB port at byte address 0; a write discards any partial matrix. Feed the
// elements row-major on in_element_value with in_valid; a word is taken at
// every edge with in_valid high and in_stall low. Loading accepts one
// element per cycle while in_stall is low. After the last element the
// block computes the determinant modulo 2^32 and holds in_stall high until
// the result is in the output register. For size n the computation walks
// all 2^n - 1 column subsets, with one memory read and one multiply per
// term, and then the engine hands the word to the output register.
// The result appears on out_determinant_value with out_valid and is held
// while out_stall is high; the next matrix may load while it waits, and a
// finished computation waits for the output register to free.
// Reset sets matrix_size to 2, clears the element position and empties the
// output register; the matrix memories are not cleared.
module integer_matrix_determinant #(
  parameter int MAX_DIM = imd_pkg::MAX_DIM_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [imd_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [imd_pkg::DATA_W-1:0] out_determinant_value,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [imd_pkg::CFG_AW-1:0]        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import imd_pkg::*;

  localparam int DW = $clog2(MAX_DIM+1);
  localparam int CW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW = (MAX_DIM > 1) ? $clog2(MAX_DIM*MAX_DIM) : 1;

  logic [SIZE_W-1:0] size_r;
  logic [CW-1:0]     ld_row_r, ld_col_r;
  logic              busy_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_det_r;

  logic              cfg_wr;
  logic              in_acc;
  logic [DW-1:0]     dim, dim_m1;
  logic              last_col, last_row;
  logic [AW-1:0]     mat_waddr, mat_raddr;
  logic [DATA_W-1:0] mat_rdata;
  eng_req_t          req;
  eng_rsp_t          rsp;

  assign pready = 1'b1;
  assign prdata = 32'(size_r);
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_MATRIX_SIZE);

  always_comb begin
    if (size_r == '0) begin
      dim = DW'(1);
    end else if (int'(size_r) > MAX_DIM) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(size_r);
    end
  end

  assign dim_m1    = dim - DW'(1);
  assign last_col  = (DW'(ld_col_r) == dim_m1);
  assign last_row  = (DW'(ld_row_r) == dim_m1);
  assign in_stall  = busy_r;
  assign in_acc    = in_valid && !busy_r;
  assign mat_waddr = AW'(int'(ld_row_r) * MAX_DIM + int'(ld_col_r));

  assign req.start     = in_acc && last_col && last_row;
  assign req.res_ready = !out_valid_r || !out_stall;

  imd_ram #(.W(DATA_W), .D(MAX_DIM*MAX_DIM)) u_mat_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (mat_waddr),
    .wdata (in_element_value),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  imd_engine #(.MAX_DIM(MAX_DIM)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .dim       (dim),
    .mat_raddr (mat_raddr),
    .mat_rdata (mat_rdata),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      ld_row_r    <= '0;
      ld_col_r    <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        size_r   <= pwdata[SIZE_W-1:0];
        ld_row_r <= '0;
        ld_col_r <= '0;
      end else if (in_acc) begin
        if (last_col) begin
          ld_col_r <= '0;
          ld_row_r <= last_row ? '0 : ld_row_r + CW'(1);
        end else begin
          ld_col_r <= ld_col_r + CW'(1);
        end
      end
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (rsp.done) begin
        busy_r <= 1'b0;
      end
      // load a new word, else drop the taken one
      if (rsp.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (rsp.done) begin
      out_det_r <= rsp.det;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_determinant_value = out_det_r;

endmodule
